[src/fqsplit_pkg.sv]
// Shared types and constants for the FASTQ record splitter with tile filter.
// No dependencies; every other file of the block but fqsplit_if imports this package.
`timescale 1ns / 1ps

package fqsplit_pkg;

  // Characters the parser cares about
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;

  // Tile field rules
  localparam logic [2:0] COLONS_FMT0    = 3'd2;
  localparam logic [2:0] COLONS_FMT1    = 3'd4;
  localparam logic [2:0] TILE_MIN_CHARS = 3'd4;
  localparam logic [2:0] TILE_MAX_CHARS = 3'd5;
  localparam logic [2:0] TILE_SET_SIZE  = 3'd4;

  // Line positions inside a record
  localparam logic [1:0] LINE_NAME    = 2'd0;
  localparam logic [1:0] LINE_SEQ     = 2'd1;
  localparam logic [1:0] LINE_QUAL    = 2'd3;

  localparam int TILE_W      = 18;
  localparam int NUM_W       = 17;
  localparam int OUT_LEN_W   = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;
  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [TILE_W-1:0] tile_t;

  typedef enum logic [1:0] {
    PH_SKIP_WS,
    PH_DIGITS,
    PH_DONE
  } num_phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FILTER_ENABLE,
    CFG_NAME_FORMAT,
    CFG_TILE_COUNT,
    CFG_TILE_A,
    CFG_TILE_B,
    CFG_TILE_C,
    CFG_TILE_D
  } cfg_reg_t;

  // Filter settings handed to the back end
  typedef struct packed {
    logic                               filter_enable;
    logic [2:0]                         tile_count;
    logic [TILE_SET_SIZE-1:0][TILE_W-1:0] tile_set;
  } filt_cfg_t;

  // Name-line summary of one record
  typedef struct packed {
    logic  tile_found;
    tile_t tile_number;
  } tile_info_t;

endpackage

[src/fqsplit_if.sv]
// Handshake channels of the FASTQ record splitter: byte input and record result.
// Has no dependencies on other files.
`timescale 1ns / 1ps

interface fqsplit_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface fqsplit_out_if;
  logic                     valid;
  logic                     ready;
  logic                     record_kept;
  logic                     tile_found;
  logic signed [17:0]       tile_number;
  logic                     length_error;
  logic [15:0]              sequence_length;
  logic [15:0]              quality_length;

  modport source (output valid, output record_kept, output tile_found, output tile_number,
                  output length_error, output sequence_length, output quality_length,
                  input ready);
  modport sink   (input valid, input record_kept, input tile_found, input tile_number,
                  input length_error, input sequence_length, input quality_length,
                  output ready);
endinterface

[src/fqsplit_front.sv]
// Front end: scans one byte per cycle unless the queue is full; tracks lines, colons, tile
// digits and line lengths. Emits a record summary at the end of each quality line.
`timescale 1ns / 1ps

module fqsplit_front #(
  parameter int LINE_LENGTH_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [7:0]                    text_byte,
  input  logic                          final_byte,
  input  logic                          name_format,
  output logic                          push,
  output fqsplit_pkg::tile_info_t       rec_tile,
  output logic [LINE_LENGTH_BITS-1:0]   rec_seq_len,
  output logic [LINE_LENGTH_BITS-1:0]   rec_qual_len
);
  import fqsplit_pkg::*;

  localparam logic [LINE_LENGTH_BITS-1:0] LEN_MAX = {LINE_LENGTH_BITS{1'b1}};

  logic [1:0]                  line_r,   line_nxt;
  logic [2:0]                  colon_r,  colon_nxt;
  logic [2:0]                  chars_r,  chars_nxt;
  num_phase_t                  phase_r,  phase_nxt;
  logic                        neg_r,    neg_nxt;
  logic [NUM_W-1:0]            value_r,  value_nxt;
  logic [LINE_LENGTH_BITS-1:0] seq_r,    seq_nxt;
  logic [LINE_LENGTH_BITS-1:0] qual_r,   qual_nxt;
  logic                        cut_r,    cut_nxt;

  // State after the byte itself, before any line end
  logic [2:0]                  colon_1, chars_1;
  num_phase_t                  phase_1;
  logic                        neg_1, cut_1;
  logic [NUM_W-1:0]            value_1;
  logic [LINE_LENGTH_BITS-1:0] seq_1, qual_1;

  logic             is_nl, is_ws, is_digit, is_sign, rec_end, found;
  logic [2:0]       target;
  logic [NUM_W-1:0] value_x10;
  logic [TILE_W-1:0] mag;

  assign is_nl     = (text_byte == CHAR_NEWLINE);
  assign is_ws     = (text_byte == CHAR_SPACE) || (text_byte >= CHAR_TAB && text_byte <= CHAR_CR);
  assign is_digit  = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
  assign is_sign   = (text_byte == CHAR_PLUS) || (text_byte == CHAR_MINUS);
  assign target    = name_format ? COLONS_FMT1 : COLONS_FMT0;
  assign value_x10 = (value_r << 3) + (value_r << 1) + {{(NUM_W-4){1'b0}}, text_byte[3:0]};

  // Byte step
  always_comb begin
    colon_1 = colon_r;
    chars_1 = chars_r;
    phase_1 = phase_r;
    neg_1   = neg_r;
    value_1 = value_r;
    seq_1   = seq_r;
    qual_1  = qual_r;
    cut_1   = cut_r;
    if (!is_nl && !cut_r) begin
      if (text_byte == CHAR_NUL) begin
        cut_1 = 1'b1;
      end else begin
        case (line_r)
          LINE_NAME: begin
            if (colon_r < target) begin
              if (text_byte == CHAR_COLON) colon_1 = colon_r + 3'd1;
            end else if (chars_r < TILE_MAX_CHARS) begin
              chars_1 = chars_r + 3'd1;
              case (phase_r)
                PH_SKIP_WS: begin
                  if (is_ws) begin
                    phase_1 = PH_SKIP_WS;
                  end else if (is_sign) begin
                    neg_1   = (text_byte == CHAR_MINUS);
                    phase_1 = PH_DIGITS;
                  end else if (is_digit) begin
                    value_1 = value_x10;
                    phase_1 = PH_DIGITS;
                  end else begin
                    phase_1 = PH_DONE;
                  end
                end
                PH_DIGITS: begin
                  if (is_digit) value_1 = value_x10;
                  else          phase_1 = PH_DONE;
                end
                default: ;
              endcase
            end
          end
          LINE_SEQ:  if (seq_r != LEN_MAX)  seq_1  = seq_r + LINE_LENGTH_BITS'(1);
          LINE_QUAL: if (qual_r != LEN_MAX) qual_1 = qual_r + LINE_LENGTH_BITS'(1);
          default: ;
        endcase
      end
    end
  end

  // A record closes on the quality line's newline, real or supplied at end of stream
  assign rec_end = (line_r == LINE_QUAL) && (is_nl || final_byte);
  assign push    = accept && rec_end;

  assign found = (colon_1 >= target) && (chars_1 >= TILE_MIN_CHARS);
  assign mag   = {1'b0, value_1};
  assign rec_tile.tile_found  = found;
  assign rec_tile.tile_number = !found ? '0 : (neg_1 ? -$signed(mag) : $signed(mag));
  assign rec_seq_len  = seq_1;
  assign rec_qual_len = qual_1;

  always_comb begin
    line_nxt  = line_r;
    colon_nxt = colon_r;
    chars_nxt = chars_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    value_nxt = value_r;
    seq_nxt   = seq_r;
    qual_nxt  = qual_r;
    cut_nxt   = cut_r;
    if (accept) begin
      if (final_byte || (is_nl && line_r == LINE_QUAL)) begin
        line_nxt  = '0;
        colon_nxt = '0;
        chars_nxt = '0;
        phase_nxt = PH_SKIP_WS;
        neg_nxt   = 1'b0;
        value_nxt = '0;
        seq_nxt   = '0;
        qual_nxt  = '0;
        cut_nxt   = 1'b0;
      end else if (is_nl) begin
        line_nxt = line_r + 2'd1;
        cut_nxt  = 1'b0;
      end else begin
        colon_nxt = colon_1;
        chars_nxt = chars_1;
        phase_nxt = phase_1;
        neg_nxt   = neg_1;
        value_nxt = value_1;
        seq_nxt   = seq_1;
        qual_nxt  = qual_1;
        cut_nxt   = cut_1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r  <= '0;
      colon_r <= '0;
      chars_r <= '0;
      phase_r <= PH_SKIP_WS;
      neg_r   <= 1'b0;
      value_r <= '0;
      seq_r   <= '0;
      qual_r  <= '0;
      cut_r   <= 1'b0;
    end else begin
      line_r  <= line_nxt;
      colon_r <= colon_nxt;
      chars_r <= chars_nxt;
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      value_r <= value_nxt;
      seq_r   <= seq_nxt;
      qual_r  <= qual_nxt;
      cut_r   <= cut_nxt;
    end
  end

endmodule

[src/fqsplit_queue.sv]
// Short FIFO of record summaries between the front and back ends.
// Depends on fqsplit_pkg for its depth.
`timescale 1ns / 1ps

module fqsplit_queue #(
  parameter int WIDTH = 51
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  import fqsplit_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop)      count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
`endif

endmodule

[src/fqsplit_back.sv]
// Back end: applies the tile filter and length check, holds the result register.
// Depends on fqsplit_pkg and the output channel interface.
`timescale 1ns / 1ps

module fqsplit_back #(
  parameter int LINE_LENGTH_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fqsplit_pkg::filt_cfg_t      cfg,
  input  logic                        q_empty,
  input  fqsplit_pkg::tile_info_t     q_tile,
  input  logic [LINE_LENGTH_BITS-1:0] q_seq_len,
  input  logic [LINE_LENGTH_BITS-1:0] q_qual_len,
  output logic                        pop,
  fqsplit_out_if.source               out_chan
);
  import fqsplit_pkg::*;

  logic        valid_r, valid_nxt;
  logic        kept_r, found_r, err_r;
  tile_t       tile_r;
  logic [OUT_LEN_W-1:0] seq_r, qual_r;

  logic        match, kept, err;
  logic [OUT_LEN_W-1:0] seq_o, qual_o;

  always_comb begin
    match = 1'b0;
    for (int i = 0; i < TILE_SET_SIZE; i++) begin
      if (cfg.tile_count > 3'(i) && q_tile.tile_found &&
          cfg.tile_set[i] == q_tile.tile_number) match = 1'b1;
    end
  end

  assign kept = !(cfg.filter_enable && match);
  assign err  = kept && (q_seq_len > q_qual_len);

  // Clamp line lengths to the 16-bit result fields, or zero-extend narrower ones
  generate
    if (LINE_LENGTH_BITS > OUT_LEN_W) begin : g_clamp
      assign seq_o  = (|q_seq_len[LINE_LENGTH_BITS-1:OUT_LEN_W])  ? '1
                                                                  : q_seq_len[OUT_LEN_W-1:0];
      assign qual_o = (|q_qual_len[LINE_LENGTH_BITS-1:OUT_LEN_W]) ? '1
                                                                  : q_qual_len[OUT_LEN_W-1:0];
    end else begin : g_ext
      assign seq_o  = OUT_LEN_W'(q_seq_len);
      assign qual_o = OUT_LEN_W'(q_qual_len);
    end
  endgenerate

  assign pop = !q_empty && (!valid_r || out_chan.ready);

  always_comb begin
    valid_nxt = valid_r;
    if (pop)                 valid_nxt = 1'b1;
    else if (out_chan.ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kept_r  <= kept;
      found_r <= q_tile.tile_found;
      tile_r  <= q_tile.tile_number;
      err_r   <= err;
      seq_r   <= seq_o;
      qual_r  <= qual_o;
    end
  end

  assign out_chan.valid           = valid_r;
  assign out_chan.record_kept     = kept_r;
  assign out_chan.tile_found      = found_r;
  assign out_chan.tile_number     = tile_r;
  assign out_chan.length_error    = err_r;
  assign out_chan.sequence_length = seq_r;
  assign out_chan.quality_length  = qual_r;

`ifndef SYNTH
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_chan.ready |-> !pop)
    else $error("result register overwritten while stalled");
  a_err_only_kept: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> !(err_r && !kept_r))
    else $error("length error flagged on dropped record");
  a_drop_needs_tile: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !kept_r |-> found_r)
    else $error("record dropped without a tile");
`endif

endmodule

[src/fastq_record_splitter_tile_filter.sv]
// Top level of the FASTQ record splitter with tile filter.
// Depends on fqsplit_pkg, fqsplit_if, fqsplit_front, fqsplit_queue and fqsplit_back.
`timescale 1ns / 1ps

// Usage
//   in_chan  : one text byte per item, with final_byte set on the last byte of a file.
//              A missing trailing newline is supplied; a partial record is discarded.
//   out_chan : one item per completed four-line record (name, sequence, '+', quality).
//   cfg_*    : write-only registers (filter enable, name format, tile count, four tiles),
//              written only while the block is idle (user's duty; not enforced).
// Throughput: one byte per cycle, sustained; the front end's byte scan is a single
//   register stage and never waits except when the record queue is full.
// Result path: a record's closing byte pushes its summary into the queue; the back end
//   then loads it into the result register once that register is free.
// Stall: the back end holds its result register while out_chan.ready is low; the two-entry
//   queue keeps taking records, and in_chan.ready drops only once it is full.
// Reset: synchronous rst_n clears the parser, the queue and the result valid, and sets all
//   configuration registers to zero (filter off, format with the tile after two colons).

module fastq_record_splitter_tile_filter #(
  parameter int LINE_LENGTH_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  fqsplit_in_if.sink                            in_chan,
  fqsplit_out_if.source                         out_chan,
  input  logic                                  cfg_we,
  input  logic [fqsplit_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fqsplit_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import fqsplit_pkg::*;

  localparam int REC_W = 1 + TILE_W + 2 * LINE_LENGTH_BITS;

  // Configuration registers
  logic        filter_en_r;
  logic        name_fmt_r;
  logic [2:0]  tile_cnt_r;
  logic [TILE_SET_SIZE-1:0][TILE_W-1:0] tile_set_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r <= 1'b0;
      name_fmt_r  <= 1'b0;
      tile_cnt_r  <= '0;
      tile_set_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FILTER_ENABLE: filter_en_r   <= cfg_wdata[0];
        CFG_NAME_FORMAT:   name_fmt_r    <= cfg_wdata[0];
        CFG_TILE_COUNT:    tile_cnt_r    <= cfg_wdata[2:0];
        CFG_TILE_A:        tile_set_r[0] <= cfg_wdata;
        CFG_TILE_B:        tile_set_r[1] <= cfg_wdata;
        CFG_TILE_C:        tile_set_r[2] <= cfg_wdata;
        CFG_TILE_D:        tile_set_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  filt_cfg_t filt_cfg;
  assign filt_cfg.filter_enable = filter_en_r;
  assign filt_cfg.tile_count    = tile_cnt_r;
  assign filt_cfg.tile_set      = tile_set_r;

  // Front end: byte scan
  logic                        accept, push, q_full, q_empty, pop;
  tile_info_t                  f_tile, q_tile;
  logic [LINE_LENGTH_BITS-1:0] f_seq, f_qual, q_seq, q_qual;
  logic [REC_W-1:0]            q_rdata;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;

  fqsplit_front #(.LINE_LENGTH_BITS(LINE_LENGTH_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .text_byte    (in_chan.text_byte),
    .final_byte   (in_chan.final_byte),
    .name_format  (name_fmt_r),
    .push         (push),
    .rec_tile     (f_tile),
    .rec_seq_len  (f_seq),
    .rec_qual_len (f_qual)
  );

  // Record queue
  fqsplit_queue #(.WIDTH(REC_W)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({f_tile, f_seq, f_qual}),
    .pop   (pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign {q_tile, q_seq, q_qual} = q_rdata;

  // Back end: filter, length check, result register
  fqsplit_back #(.LINE_LENGTH_BITS(LINE_LENGTH_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (filt_cfg),
    .q_empty    (q_empty),
    .q_tile     (q_tile),
    .q_seq_len  (q_seq),
    .q_qual_len (q_qual),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule
